FILE: rtl/tlhb_pkg.sv
// Shared types and constants for the two-level history branch target buffer.
package tlhb_pkg;

    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 64;
    localparam int HIST_W     = 16;
    localparam int TAG_W      = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPEC    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECOVER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_XOR_INDEX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_REPLACE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS       = 2'd3;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // input word: cmd, pc, actual_target, taken, predicted, saved_history
    localparam int S_DATA_W = 152;
    // result word: predicted_target, hit, lookup_history
    localparam int M_DATA_W = 88;

    typedef struct packed {
        logic              xor_index;
        logic              random_replace;
        logic [4:0]        history_width;
        logic [4:0]        tag_bits;
    } cfg_t;

    typedef struct packed {
        logic [HIST_W-1:0] saved_history;
        logic              predicted;
        logic              taken;
        logic [ADDR_W-1:0] actual_target;
        logic [ADDR_W-1:0] pc;
        logic [CMD_W-1:0]  cmd;
    } req_t;

    // saturate history width to the kept maximum
    function automatic logic [5:0] eff_hw(input logic [4:0] hw, input int hmax);
        logic [5:0] r;
        r = (int'(hw) > hmax) ? 6'(hmax) : {1'b0, hw};
        return r;
    endfunction

    function automatic logic [HIST_W-1:0] hmask(input logic [5:0] hw);
        logic [HIST_W:0] m;
        m = ({{HIST_W{1'b0}}, 1'b1} << hw) - 1'b1;
        return m[HIST_W-1:0];
    endfunction

endpackage

FILE: rtl/tlhb_hist.sv
// Per-PC history table: memory with registered read and a clearing pass after reset.
module tlhb_hist #(
    parameter int HIST_ENTRIES = 1024
) (
    input  logic                    aclk,
    input  logic                    rd_en,
    input  logic [$clog2(HIST_ENTRIES > 1 ? HIST_ENTRIES : 2)-1:0] rd_addr,
    output logic [tlhb_pkg::HIST_W-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [$clog2(HIST_ENTRIES > 1 ? HIST_ENTRIES : 2)-1:0] wr_addr,
    input  logic [tlhb_pkg::HIST_W-1:0] wr_data,
    input  logic                    aresetn
);
    import tlhb_pkg::*;
    localparam int AW = $clog2(HIST_ENTRIES > 1 ? HIST_ENTRIES : 2);
    localparam int CW = $clog2(HIST_ENTRIES + 1);

    logic [HIST_W-1:0] mem [HIST_ENTRIES];
    logic [HIST_W-1:0] q_reg;
    logic [CW-1:0]     clr_reg;
    logic [AW-1:0]     waddr;
    logic [HIST_W-1:0] wdata;
    logic              we;

    // clearing pass after reset
    always_comb begin
        if (clr_reg < CW'(HIST_ENTRIES)) begin
            we = 1'b1; waddr = clr_reg[AW-1:0]; wdata = '0;
        end else begin
            we = wr_en; waddr = wr_addr; wdata = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (clr_reg < CW'(HIST_ENTRIES)) clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) q_reg <= mem[rd_addr];
    end

    assign rd_data = q_reg;
endmodule

FILE: rtl/tlhb_store.sv
// Way store: tags, targets and recency ranks of one set held in one wide memory row.
module tlhb_store #(
    parameter int SETS = 512,
    parameter int WAYS = 4
) (
    input  logic aclk,
    input  logic aresetn,
    output logic clr_busy,
    input  logic rd_en,
    input  logic [$clog2(SETS > 1 ? SETS : 2)-1:0] rd_addr,
    output logic [WAYS*(tlhb_pkg::TAG_W+tlhb_pkg::ADDR_W+$clog2(WAYS > 1 ? WAYS : 2))-1:0] rd_row,
    input  logic wr_en,
    input  logic [$clog2(SETS > 1 ? SETS : 2)-1:0] wr_addr,
    input  logic [WAYS*(tlhb_pkg::TAG_W+tlhb_pkg::ADDR_W+$clog2(WAYS > 1 ? WAYS : 2))-1:0] wr_row
);
    import tlhb_pkg::*;
    localparam int SW = $clog2(SETS > 1 ? SETS : 2);
    localparam int RW = $clog2(WAYS > 1 ? WAYS : 2);
    localparam int EW = TAG_W + ADDR_W + RW;
    localparam int CW = $clog2(SETS + 1);

    logic [WAYS*EW-1:0] mem [SETS];
    logic [WAYS*EW-1:0] q_reg;
    logic [CW-1:0]      clr_reg;
    logic [WAYS*EW-1:0] init_row;
    logic [SW-1:0]      waddr;
    logic [WAYS*EW-1:0] wdata;
    logic               we;

    // entry layout: {rank, target, tag}; reset row has rank == way
    always_comb begin
        for (int w = 0; w < WAYS; w++)
            init_row[w*EW +: EW] = {RW'(w), {(TAG_W+ADDR_W){1'b0}}};
    end

    assign clr_busy = clr_reg < CW'(SETS);

    always_comb begin
        if (clr_busy) begin
            we = 1'b1; waddr = clr_reg[SW-1:0]; wdata = init_row;
        end else begin
            we = wr_en; waddr = wr_addr; wdata = wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (clr_busy) clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) q_reg <= mem[rd_addr];
    end

    assign rd_row = q_reg;
endmodule

FILE: rtl/two_level_history_btb.sv
// Top level: two-level history BTB with command sequencer and result register.
//
// channel | dir | word
// s_axis  | in  | tdata: cmd, pc, actual_target, taken, predicted, saved_history
// m_axis  | out | tdata: predicted_target, hit, lookup_history
// cfg     | in  | index 0..3, 5-bit data
//
// Lookup steps: accept, history read, set read, way check, result load.
// Taken update steps: accept, history read, set read, row modify/write.
// Spec-update does a history read-modify-write; other commands finish at accept.
// After reset a clearing pass of both tables holds s_axis_tready low.
// One word is in work at a time; a lookup result waits in the output register while
// the next word is accepted, and the sequencer stalls only if a second result is due.
module two_level_history_btb #(
    parameter int SETS         = 512,
    parameter int WAYS         = 4,
    parameter int HIST_ENTRIES = 1024,
    parameter int HIST_MAX     = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cmd[2:0], pc[66:3], actual_target[130:67], taken[131], predicted[132],
    // saved_history[148:133], zero fill
    input  logic [tlhb_pkg::S_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // predicted_target[63:0], hit[64], lookup_history[80:65], zero fill
    output logic [tlhb_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [tlhb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlhb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tlhb_pkg::*;
    localparam int SW  = $clog2(SETS > 1 ? SETS : 2);
    localparam int LS  = $clog2(SETS) - ((SETS & (SETS - 1)) != 0 ? 1 : 0);
    localparam int RW  = $clog2(WAYS > 1 ? WAYS : 2);
    localparam int EW  = TAG_W + ADDR_W + RW;
    localparam int HAW = $clog2(HIST_ENTRIES > 1 ? HIST_ENTRIES : 2);
    localparam int CLR = (SETS > HIST_ENTRIES) ? SETS : HIST_ENTRIES;
    localparam int CCW = $clog2(CLR + 1);

    typedef enum logic [2:0] {S_IDLE, S_HRD, S_SRD, S_MOD, S_OUT} state_t;

    cfg_t          cfg_reg;
    state_t        state_reg;
    req_t          req_reg;
    logic [HIST_W-1:0] h_reg;
    logic [SW-1:0] set_reg;
    logic [31:0]   lfsr_reg;
    logic          mvalid_reg;
    logic [M_DATA_W-1:0] mdata_reg;
    logic [CCW-1:0] boot_reg;

    req_t          s_req;
    logic          s_fire;
    logic [HIST_W-1:0] hrd;
    logic [WAYS*EW-1:0] row_q, row_w;
    logic          hwe, swe, hre, sre;
    logic [HAW-1:0] hraddr, hwaddr;
    logic [HIST_W-1:0] hwdata;
    logic [SW-1:0] sraddr;
    logic          st_busy;
    logic [5:0]    hw;
    logic [HIST_W-1:0] hm;
    logic [4:0]    tb;
    logic [TAG_W-1:0] tag_c;
    logic [SW-1:0] set_c;
    logic [HIST_W-1:0] hsel;
    logic          found;
    logic [RW-1:0] fway, vway, uway;
    logic [RW-1:0] best_rank;
    logic [31:0]   lfsr_nx;
    logic [RW-1:0] vrank;

    assign s_req = req_t'(s_axis_tdata[$bits(req_t)-1:0]);
    assign hw    = eff_hw(cfg_reg.history_width, HIST_MAX);
    assign hm    = hmask(hw);
    assign tb    = (cfg_reg.tag_bits > 5'd30) ? 5'd30 : cfg_reg.tag_bits;

    function automatic logic [HAW-1:0] hidx(input logic [ADDR_W-1:0] pc);
        logic [ADDR_W-1:0] r;
        r = pc % ADDR_W'(HIST_ENTRIES);
        return r[HAW-1:0];
    endfunction

    // accept only when idle and the clearing pass is done
    assign s_axis_tready = (state_reg == S_IDLE) && (boot_reg == CCW'(CLR)) && !st_busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    tlhb_hist #(.HIST_ENTRIES(HIST_ENTRIES)) u_hist (
        .aclk(aclk), .aresetn(aresetn), .rd_en(hre), .rd_addr(hraddr), .rd_data(hrd),
        .wr_en(hwe), .wr_addr(hwaddr), .wr_data(hwdata)
    );

    tlhb_store #(.SETS(SETS), .WAYS(WAYS)) u_store (
        .aclk(aclk), .aresetn(aresetn), .clr_busy(st_busy), .rd_en(sre),
        .rd_addr(sraddr), .rd_row(row_q), .wr_en(swe), .wr_addr(set_reg), .wr_row(row_w)
    );

    assign hre    = s_fire;
    assign hraddr = hidx(s_req.pc);

    // set index from pc and history (history from table or saved word)
    always_comb begin
        logic [ADDR_W-1:0] idx;
        int sh;
        hsel = ((req_reg.cmd == CMD_UPDATE) ? req_reg.saved_history : hrd) & hm;
        sh   = (LS > int'(hw)) ? LS - int'(hw) : 0;
        if (cfg_reg.xor_index)
            idx = req_reg.pc ^ ({{(ADDR_W-HIST_W){1'b0}}, hsel} << sh);
        else
            idx = (req_reg.pc << hw) | {{(ADDR_W-HIST_W){1'b0}}, hsel};
        idx   = idx & ADDR_W'(SETS - 1);
        idx   = idx % ADDR_W'(SETS);
        set_c = idx[SW-1:0];
    end

    always_comb begin
        logic [ADDR_W-1:0] t;
        t     = (req_reg.pc >> LS) & ((64'd1 << tb) - 64'd1);
        tag_c = t[TAG_W-1:0];
    end

    assign sre    = (state_reg == S_SRD);
    assign sraddr = set_c;

    // way search on the row read back
    always_comb begin
        found = 1'b0; fway = '0; best_rank = '0; vway = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (row_q[w*EW +: TAG_W] == tag_c &&
                (!found || row_q[w*EW+TAG_W+ADDR_W +: RW] < best_rank)) begin
                found = 1'b1; fway = RW'(w);
                best_rank = row_q[w*EW+TAG_W+ADDR_W +: RW];
            end
        end
        lfsr_nx = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
        vrank   = cfg_reg.random_replace ? RW'(lfsr_nx % 32'(WAYS)) : RW'(WAYS - 1);
        for (int w = WAYS - 1; w >= 0; w--)
            if (row_q[w*EW+TAG_W+ADDR_W +: RW] == vrank) vway = RW'(w);
        uway = found ? fway : vway;
    end

    always_comb begin
        logic [RW-1:0] r, rk;
        r     = row_q[uway*EW+TAG_W+ADDR_W +: RW];
        row_w = row_q;
        for (int w = 0; w < WAYS; w++) begin
            rk = row_q[w*EW+TAG_W+ADDR_W +: RW];
            if (rk < r) row_w[w*EW+TAG_W+ADDR_W +: RW] = rk + 1'b1;
        end
        row_w[uway*EW+TAG_W+ADDR_W +: RW] = '0;
        row_w[uway*EW+TAG_W +: ADDR_W]    = req_reg.actual_target;
        if (!found) row_w[uway*EW +: TAG_W] = tag_c;
    end

    assign swe = (state_reg == S_MOD) && (req_reg.cmd == CMD_UPDATE);

    // history writes: spec update here, recover and flush only for one-entry tables
    always_comb begin
        hwe    = 1'b0;
        hwaddr = hidx(req_reg.pc);
        hwdata = '0;
        if (state_reg == S_SRD && req_reg.cmd == CMD_SPEC) begin
            hwe    = 1'b1;
            hwdata = ((hrd & hm) << 1 | {{(HIST_W-1){1'b0}}, req_reg.predicted}) & hm;
        end else if (s_fire && HIST_ENTRIES == 1 && s_req.cmd == CMD_RECOVER) begin
            hwe    = 1'b1;
            hwaddr = '0;
            hwdata = (((s_req.saved_history & hm) << 1) |
                      {{(HIST_W-1){1'b0}}, s_req.taken}) & hm;
        end else if (s_fire && HIST_ENTRIES == 1 && s_req.cmd == CMD_FLUSH) begin
            hwe    = 1'b1;
            hwaddr = '0;
            hwdata = s_req.saved_history & hm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= '{xor_index: 1'b1, random_replace: 1'b0,
                            history_width: 5'd8, tag_bits: 5'd16};
            state_reg  <= S_IDLE;
            lfsr_reg   <= 32'd1;
            mvalid_reg <= 1'b0;
            boot_reg   <= '0;
        end else begin
            if (boot_reg != CCW'(CLR)) boot_reg <= boot_reg + 1'b1;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_XOR_INDEX:      cfg_reg.xor_index      <= cfg_data[0];
                    REG_RANDOM_REPLACE: cfg_reg.random_replace <= cfg_data[0];
                    REG_HISTORY_WIDTH:  cfg_reg.history_width  <= cfg_data;
                    REG_TAG_BITS:       cfg_reg.tag_bits       <= cfg_data;
                    default: ;
                endcase
            end
            // in S_OUT the result load below decides the valid flag
            if (mvalid_reg && m_axis_tready && state_reg != S_OUT) mvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        req_reg <= s_req;
                        if ((s_req.cmd == CMD_UPDATE && s_req.taken) ||
                            s_req.cmd == CMD_LOOKUP || s_req.cmd == CMD_SPEC)
                            state_reg <= S_HRD;
                    end
                end
                S_HRD: state_reg <= S_SRD;
                S_SRD: begin
                    set_reg   <= set_c;
                    h_reg     <= hsel;
                    state_reg <= (req_reg.cmd == CMD_SPEC) ? S_IDLE : S_MOD;
                end
                S_MOD: begin
                    if (req_reg.cmd == CMD_UPDATE) begin
                        if (!found && cfg_reg.random_replace) lfsr_reg <= lfsr_nx;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!mvalid_reg || m_axis_tready) begin
                        mvalid_reg <= 1'b1;
                        mdata_reg  <= {7'd0, h_reg, found,
                                       found ? row_q[fway*EW+TAG_W +: ADDR_W] : 64'd0};
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    a_rst_no_result: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("word accepted while busy");
    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT) && req_reg.cmd == CMD_LOOKUP)
        else $error("result not from lookup");
    a_store_write_update: assert property (@(posedge aclk) disable iff (!aresetn)
        swe |-> req_reg.taken)
        else $error("store written by untaken update");
endmodule
